// ===== hdl/sdtf_pkg.sv =====
// Package for the signed decimal text formatter.
// Holds widths, character codes, FSM state type and the controller/datapath
// command and status structs. No dependencies.
package sdtf_pkg;

  // Width of the signed integer that is converted (8..64).
  localparam int VALUE_WIDTH = 64;
  // Decimal digits of 2^(VALUE_WIDTH-1): floor((W-1)*log10(2)) + 1.
  localparam int NUM_DIGITS  = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_W       = NUM_DIGITS * 4;
  localparam int CNT_W       = $clog2(VALUE_WIDTH);
  localparam int DCNT_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CONV = 5'b00010,
    ST_SIGN = 5'b00100,
    ST_SKIP = 5'b01000,
    ST_EMIT = 5'b10000
  } sdtf_state_t;

  typedef struct packed {
    logic load;        // capture magnitude, clear BCD
    logic step;        // one shift-add-3 iteration
    logic skip;        // drop a leading zero digit
    logic push_sign;   // put '-' into the output register
    logic push_digit;  // put top digit into the output register and shift
  } sdtf_cmd_t;

  typedef struct packed {
    logic conv_done;   // current iteration is the last one
    logic neg;         // item is negative
    logic top_zero;    // top BCD digit is zero
    logic one_left;    // one digit remains
    logic slot_free;   // output register can take a word this cycle
  } sdtf_status_t;

endpackage

// ===== hdl/sdtf_ctrl.sv =====
// Controller FSM of the signed decimal text formatter.
// Sequences load, conversion, sign, zero skipping and digit output.
// Depends on sdtf_pkg.
module sdtf_ctrl import sdtf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  sdtf_status_t status,
  output sdtf_cmd_t    cmd
);

  sdtf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd.step = 1'b1;
        if (status.conv_done) begin
          state_nxt = ST_SIGN;
        end
      end
      ST_SIGN: begin
        if (!status.neg) begin
          state_nxt = ST_SKIP;
        end else if (status.slot_free) begin
          cmd.push_sign = 1'b1;
          state_nxt     = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // keep at least one digit so zero prints as '0'
        if (status.top_zero && !status.one_left) begin
          cmd.skip = 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status.slot_free) begin
          cmd.push_digit = 1'b1;
          if (status.one_left) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/sdtf_datapath.sv =====
// Datapath of the signed decimal text formatter: magnitude and BCD shift
// registers (double dabble), counters and the output word register.
// Depends on sdtf_pkg.
module sdtf_datapath import sdtf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic [63:0]  in_value,
  input  sdtf_cmd_t    cmd,
  output sdtf_status_t status,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_char,
  output logic         out_last
);

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]       bcd_r, bcd_nxt, bcd_adj;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DCNT_W-1:0]      dcnt_r, dcnt_nxt;
  logic                   neg_r, neg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [7:0]             out_char_r, out_char_nxt;
  logic                   out_last_r, out_last_nxt;
  logic [3:0]             top_digit;

  assign raw       = in_value[VALUE_WIDTH-1:0];
  assign top_digit = bcd_r[BCD_W-1 -: 4];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    bcd_adj = bcd_r;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    cnt_nxt  = cnt_r;
    dcnt_nxt = dcnt_r;
    neg_nxt  = neg_r;
    if (cmd.load) begin
      neg_nxt  = raw[VALUE_WIDTH-1];
      // two's complement negate; most negative value yields 2^(W-1) unsigned
      mag_nxt  = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;
      bcd_nxt  = '0;
      cnt_nxt  = '0;
      dcnt_nxt = DCNT_W'(NUM_DIGITS);
    end else if (cmd.step) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VALUE_WIDTH-1]};
      mag_nxt = {mag_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.skip || cmd.push_digit) begin
      bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
      dcnt_nxt = dcnt_r - DCNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (cmd.push_sign) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_MINUS;
      out_last_nxt  = 1'b0;
    end else if (cmd.push_digit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = CHAR_ZERO + {4'd0, top_digit};
      out_last_nxt  = (dcnt_r == DCNT_W'(1));
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    dcnt_r     <= dcnt_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign status.conv_done = (cnt_r == CNT_W'(VALUE_WIDTH - 1));
  assign status.neg       = neg_r;
  assign status.top_zero  = (top_digit == 4'd0);
  assign status.one_left  = (dcnt_r == DCNT_W'(1));
  assign status.slot_free = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

endmodule

// ===== hdl/signed_decimal_text_formatter_unit.sv =====
// Signed decimal text formatter, top level.
// Instantiates sdtf_ctrl and sdtf_datapath; depends on sdtf_pkg.
//
// Input channel: in_value is a signed two's complement integer (low
// VALUE_WIDTH bits used), taken when in_valid is high and in_stall low.
// Output channel: one ASCII character per word on out_char, most significant
// first, with out_last high on the final character of a number. A negative
// number starts with '-'; zero prints as '0'; no leading zeros.
// Sequence: after acceptance the double-dabble loop runs over all VALUE_WIDTH
// bits (one bit per cycle), then the sign is checked and a '-' is loaded for a
// negative number, up to NUM_DIGITS-1 leading zeros are skipped, and the
// digit words are loaded one by one. in_stall is high from acceptance
// until the last word has been loaded into the output register; the next
// item may be taken while that word still waits.
// Output stalls hold the output register and pause the sequencer while it
// waits to load a sign or digit word; conversion and zero skipping go on.
// Synchronous active-low reset empties the output register and returns the
// controller to idle.
module signed_decimal_text_formatter_unit import sdtf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_char,
  output logic        out_last
);

  sdtf_cmd_t    cmd;
  sdtf_status_t status;

  sdtf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  sdtf_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_value  (in_value),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_char  (out_char),
    .out_last  (out_last)
  );

endmodule
